FILE: hdl/mandelbrot_escape_pixel_assert.svh
`ifndef MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH

// expr holds at every edge outside reset
`define MEP_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// cond at one edge implies expr at the next edge
`define MEP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

FILE: hdl/mep_pkg.sv
package mep_pkg;

   localparam int IDX_W      = 10;
   localparam int STEP_SHIFT = 28;
   localparam int NUM_W      = IDX_W + STEP_SHIFT;
   localparam int FRAC_BITS  = 26;
   localparam int Q_W        = 32;
   localparam int Z_W        = Q_W + 1;
   localparam int P_W        = 2 * Z_W;
   localparam int SQ_W       = P_W - FRAC_BITS;
   localparam int ITER_W     = 8;
   localparam int PIX_W      = 8;

   localparam logic signed [Q_W-1:0] ORIGIN_X = -32'sd167772160;
   localparam logic signed [Q_W-1:0] ORIGIN_Y = -32'sd134217728;
   localparam logic [SQ_W:0]         ESCAPE_Q = (SQ_W+1)'(64'd268435456);

   localparam logic [ITER_W-1:0] ITER_RESET  = 8'd200;
   localparam logic [PIX_W-1:0]  PIXEL_BLACK = 8'd0;
   localparam logic [PIX_W-1:0]  PIXEL_WHITE = 8'd255;

   typedef struct packed {
      logic load;
      logic div_step;
      logic map;
      logic mul;
      logic iter;
      logic emit;
   } mep_cmd_type;

   typedef struct packed {
      logic cont;
   } mep_sts_type;

endpackage

FILE: hdl/mandelbrot_escape_pixel.sv
// Mapping is a reciprocal multiply, then offset and saturate; each iteration has one multiply
// stage and one add/compare stage, and the loop ends when the add/compare stage finds the
// iteration limit reached or z escaped. A new request is not taken until the last one is
// emitted; a new request is taken while a result waits.
// Reset: synchronous, active high; clears control and sets max_iterations to 200.
`include "mandelbrot_escape_pixel_assert.svh"

module mandelbrot_escape_pixel
   import mep_pkg::*;
#(
   parameter int IMAGE_SIZE = 1000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [IDX_W-1:0]  req_pixel_col,
   input  logic [IDX_W-1:0]  req_pixel_row,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PIX_W-1:0]  rsp_pixel_value,
   input  logic              csr_wr_en,
   input  logic [ITER_W-1:0] csr_wr_data
);

   mep_cmd_type cmd;
   mep_sts_type sts;

   mep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mep_dp #(
      .IMAGE_SIZE (IMAGE_SIZE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_pixel_col   (req_pixel_col),
      .req_pixel_row   (req_pixel_row),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_pixel_value (rsp_pixel_value)
   );

   `MEP_ASSERT_ALWAYS(a_cmd_onehot, clock, reset,
      $onehot0({cmd.load, cmd.div_step, cmd.map, cmd.mul, cmd.iter, cmd.emit}))
   `MEP_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid))
   `MEP_ASSERT_NEXT(a_iter_then_mul, clock, reset, cmd.iter, cmd.mul)

endmodule

FILE: hdl/mep_ctrl.sv
module mep_ctrl
   import mep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  mep_sts_type sts,
   output mep_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_MAP  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_ADD  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_MAP;
         end
         ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (sts.cont) begin
               cmd.iter = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/mep_dp.sv
module mep_dp
   import mep_pkg::*;
#(
   parameter int IMAGE_SIZE = 1000
) (
   input  logic              clock,
   input  logic              reset,
   input  mep_cmd_type       cmd,
   output mep_sts_type       sts,
   input  logic [IDX_W-1:0]  req_pixel_col,
   input  logic [IDX_W-1:0]  req_pixel_row,
   input  logic              csr_wr_en,
   input  logic [ITER_W-1:0] csr_wr_data,
   output logic [PIX_W-1:0]  rsp_pixel_value
);

   localparam int LOW_W       = 22;
   localparam int RECIP_W     = LOW_W + 2;
   localparam int PROD_W      = LOW_W + RECIP_W;
   localparam int RECIP_SHIFT = LOW_W + $clog2(IMAGE_SIZE);
   localparam logic [NUM_W-1:0]   STEP_INT =
      NUM_W'((64'd1 << STEP_SHIFT) / 64'(IMAGE_SIZE));
   localparam logic [LOW_W-1:0]   STEP_REM =
      LOW_W'((64'd1 << STEP_SHIFT) % 64'(IMAGE_SIZE));
   localparam logic [LOW_W-1:0]   HALF     = LOW_W'(IMAGE_SIZE / 2);
   localparam logic [RECIP_W-1:0] RECIP    =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(IMAGE_SIZE) - 64'd1) / 64'(IMAGE_SIZE));
   localparam logic [31:0]        SIZE_32  = 32'(IMAGE_SIZE);

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [NUM_W+1:0] v);
      logic signed [Q_W-1:0] r;
      if (v[NUM_W+1:Q_W-1] == '0 || v[NUM_W+1:Q_W-1] == '1) begin
         r = v[Q_W-1:0];
      end else if (v[NUM_W+1]) begin
         r = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(Q_W-1){1'b1}}};
      end
      return r;
   endfunction

   logic [ITER_W-1:0]        max_iter_ff;
   logic [NUM_W-1:0]         hi_ff  [2];
   logic [LOW_W-1:0]         low_ff [2];
   logic [PROD_W-1:0]        prod   [2];
   logic [NUM_W-1:0]         num_ff [2];
   logic [NUM_W-1:0]         num_in [2];
   logic                     snap_ff;
   logic signed [Q_W-1:0]    cx_ff, cy_ff;
   logic signed [Z_W-1:0]    zx_ff, zy_ff, zx_in, zy_in;
   logic signed [P_W-1:0]    p_xx_ff, p_yy_ff, p_xy_ff;
   logic [ITER_W-1:0]        it_ff;
   logic [PIX_W-1:0]         pixel_ff;
   logic [SQ_W-1:0]          zx2, zy2;
   logic [SQ_W:0]            sq_sum;
   logic signed [NUM_W+1:0]  sum_x, sum_y;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         prod[i]   = PROD_W'(low_ff[i]) * PROD_W'(RECIP);
         num_in[i] = hi_ff[i] + NUM_W'(prod[i][RECIP_SHIFT +: IDX_W]);
      end
   end

   assign sum_x = (NUM_W+2)'(ORIGIN_X) + $signed({2'b00, num_ff[0]});
   assign sum_y = (NUM_W+2)'(ORIGIN_Y) + $signed({2'b00, num_ff[1]});

   assign zx2    = p_xx_ff[P_W-1:FRAC_BITS];
   assign zy2    = p_yy_ff[P_W-1:FRAC_BITS];
   assign sq_sum = {1'b0, zx2} + {1'b0, zy2};

   assign zx_in = $signed(zx2[Z_W-1:0]) - $signed(zy2[Z_W-1:0]) + Z_W'(cx_ff);
   assign zy_in = $signed(p_xy_ff[FRAC_BITS-1+Z_W-1:FRAC_BITS-1]) + Z_W'(cy_ff);

   assign sts.cont = (it_ff < max_iter_ff) && (sq_sum < ESCAPE_Q);

   assign rsp_pixel_value = pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= ITER_RESET;
      end else if (csr_wr_en) begin
         max_iter_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hi_ff[0]  <= NUM_W'(req_pixel_col) * STEP_INT;
         hi_ff[1]  <= NUM_W'(req_pixel_row) * STEP_INT;
         low_ff[0] <= LOW_W'(req_pixel_col) * STEP_REM + HALF;
         low_ff[1] <= LOW_W'(req_pixel_row) * STEP_REM + HALF;
         snap_ff   <= ({21'd0, req_pixel_row, 1'b0} == SIZE_32);
      end
      if (cmd.div_step) begin
         num_ff <= num_in;
      end
      if (cmd.map) begin
         cx_ff <= sat_q(sum_x);
         cy_ff <= snap_ff ? '0 : sat_q(sum_y);
         zx_ff <= '0;
         zy_ff <= '0;
         it_ff <= '0;
      end else if (cmd.iter) begin
         zx_ff <= zx_in;
         zy_ff <= zy_in;
         it_ff <= it_ff + 1'b1;
      end
      if (cmd.mul) begin
         p_xx_ff <= zx_ff * zx_ff;
         p_yy_ff <= zy_ff * zy_ff;
         p_xy_ff <= zx_ff * zy_ff;
      end
      if (cmd.emit) begin
         pixel_ff <= (it_ff == max_iter_ff) ? PIXEL_BLACK : PIXEL_WHITE;
      end
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mep_pkg::*;

   localparam int IMAGE_SIZE  = 1000;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 120;

   typedef struct {
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] row;
      logic [PIX_W-1:0] value;
   } pixel_expect_type;

   class escape_checker;
      localparam longint ESCAPE_SQ = longint'(4) <<< FRAC_BITS;
      localparam longint COORD_MAX = 64'sd2147483647;
      localparam longint COORD_MIN = -64'sd2147483648;

      int                image_size;
      logic [ITER_W-1:0] iter_limit;
      pixel_expect_type  expected_pixels[$];
      int                mismatches;
      int                checked;

      function new(int image_size_i);
         image_size = image_size_i;
         iter_limit = ITER_RESET;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_limit(logic [ITER_W-1:0] value);
         iter_limit = value;
      endfunction

      function longint map_axis(logic [IDX_W-1:0] idx, longint origin);
         longint num;
         longint coord;
         num   = longint'(idx) * (longint'(4) <<< FRAC_BITS) + image_size / 2;
         coord = origin + num / image_size;
         if (coord > COORD_MAX) begin
            coord = COORD_MAX;
         end else if (coord < COORD_MIN) begin
            coord = COORD_MIN;
         end
         return coord;
      endfunction

      function logic [PIX_W-1:0] escape_value(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
         longint      cx, cy, zx, zy, zx2, zy2, nzx, nzy;
         int unsigned iters;
         cx = map_axis(col, longint'(ORIGIN_X));
         cy = map_axis(row, longint'(ORIGIN_Y));
         if (2 * int'(row) == image_size) begin
            cy = 0;
         end
         zx    = 0;
         zy    = 0;
         zx2   = 0;
         zy2   = 0;
         iters = 0;
         while (iters < iter_limit && (zx2 + zy2) < ESCAPE_SQ) begin
            nzy   = ((zx * zy) >>> (FRAC_BITS - 1)) + cy;
            nzx   = zx2 - zy2 + cx;
            zx    = nzx;
            zy    = nzy;
            zx2   = (zx * zx) >>> FRAC_BITS;
            zy2   = (zy * zy) >>> FRAC_BITS;
            iters = iters + 1;
         end
         return (iters == iter_limit) ? PIXEL_BLACK : PIXEL_WHITE;
      endfunction

      function void note_request(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
         pixel_expect_type item;
         item.col   = col;
         item.row   = row;
         item.value = escape_value(col, row);
         expected_pixels.push_back(item);
      endfunction

      function void check_result(logic [PIX_W-1:0] got);
         pixel_expect_type item;
         checked = checked + 1;
         if (expected_pixels.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
               $display("unexpected result %0d with no request outstanding", got);
            end
            return;
         end
         item = expected_pixels.pop_front();
         if (got !== item.value) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
               $display("mismatch at pixel (%0d,%0d) limit %0d: expected %0d, got %0d",
                        item.col, item.row, iter_limit, item.value, got);
            end
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [IDX_W-1:0]  req_pixel_col;
   logic [IDX_W-1:0]  req_pixel_row;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [PIX_W-1:0]  rsp_pixel_value;
   logic              csr_wr_en;
   logic [ITER_W-1:0] csr_wr_data;

   escape_checker checker_h;
   bit            steady;
   int            cycles;
   int            sent;
   int            settings;

   mandelbrot_escape_pixel #(
      .IMAGE_SIZE(IMAGE_SIZE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel_col(req_pixel_col),
      .req_pixel_row(req_pixel_row),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel_value(rsp_pixel_value),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 15);
      end
      return $urandom_range(20, 80);
   endfunction

   // entered just after a falling edge
   task automatic send_pixel(int col, int row);
      int gap;
      req_pixel_col = col[IDX_W-1:0];
      req_pixel_row = row[IDX_W-1:0];
      req_valid     = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
      sent = sent + 1;
      gap  = idle_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      while (checker_h.pending() != 0) begin
         @(negedge clock);
      end
   endtask

   // only while idle
   task automatic write_limit(int value);
      req_valid = 1'b0;
      wait_drained();
      csr_wr_data = value[ITER_W-1:0];
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      checker_h.set_limit(value[ITER_W-1:0]);
      settings = settings + 1;
   endtask

   task automatic send_random_pixel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      end else if (r < 90) begin
         // bias toward the set and its boundary
         send_pixel($urandom_range(125, 750), $urandom_range(250, 750));
      end else if (r < 95) begin
         send_pixel($urandom_range(0, 1023), IMAGE_SIZE / 2);
      end else begin
         send_pixel($urandom_range(IMAGE_SIZE, 1023), $urandom_range(IMAGE_SIZE - 24, 1023));
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, checker_h.pending());
         $display("[mandelbrot_escape_pixel] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            checker_h.note_request(req_pixel_col, req_pixel_row);
         end
         if (rsp_valid && rsp_ready) begin
            checker_h.check_result(rsp_pixel_value);
         end
      end
   end

   initial begin
      int gap;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         rsp_ready = 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         gap = idle_gap();
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   initial begin
      int limit;
      checker_h     = new(IMAGE_SIZE);
      cycles        = 0;
      sent          = 0;
      settings      = 0;
      steady        = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pixel_col = '0;
      req_pixel_row = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset limit: corners, out-of-image indexes, axis snap, c = -2 and c = 0
      send_pixel(0, 0);
      send_pixel(999, 999);
      send_pixel(0, 999);
      send_pixel(999, 0);
      send_pixel(1023, 1023);
      send_pixel(1023, 0);
      send_pixel(0, 1023);
      send_pixel(500, 500);
      send_pixel(625, 500);
      send_pixel(625, 499);
      send_pixel(625, 501);
      send_pixel(375, 500);
      send_pixel(125, 500);
      send_pixel(124, 500);
      send_pixel(750, 500);
      send_pixel(1000, 500);
      send_pixel(682, 341);
      send_pixel(341, 682);

      write_limit(0);
      send_pixel(625, 500);
      send_pixel(0, 0);
      write_limit(1);
      send_pixel(125, 500);
      send_pixel(0, 0);
      write_limit(255);
      send_pixel(625, 500);
      send_pixel(760, 500);
      send_pixel(1023, 1023);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            limit = 255;
         end else if (phase == 1) begin
            limit = 1;
         end else if (phase == 2) begin
            limit = 2;
         end else begin
            limit = $urandom_range(1, 255);
         end
         write_limit(limit);
         steady = (phase % 4 == 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_pixel();
         end
      end

      steady    = 1'b0;
      req_valid = 1'b0;
      wait_drained();
      repeat (600) @(negedge clock);

      $display("covered %0d pixel requests over %0d iteration-limit settings",
               sent, settings);
      $display("compared %0d results, %0d mismatches", checker_h.checked,
               checker_h.mismatches);
      if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
         $display("[mandelbrot_escape_pixel] OK");
      end else begin
         $display("[mandelbrot_escape_pixel] ERROR");
      end
      $finish;
   end

endmodule
